### design/arpc_pkg.sv
// ============================================================================
// arpc_pkg: shared types and constants for the ARP cache responder
// Word formats of both channels, the classified queue entry and field codes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package arpc_pkg;

    // command codes of the input word
    localparam logic [1:0] CMD_RECEIVE = 2'd0;
    localparam logic [1:0] CMD_LOOKUP  = 2'd1;
    localparam logic [1:0] CMD_SEND    = 2'd2;

    // ARP header fields that a frame must carry
    localparam logic [15:0] HW_TYPE_ETH    = 16'd1;
    localparam logic [15:0] PROTO_IPV4     = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

    // opcodes of sent frames
    localparam logic [1:0] OPC_REQUEST = 2'd1;
    localparam logic [1:0] OPC_REPLY   = 2'd2;

    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] REG_OWN_MAC   = 2'd0;
    localparam logic [1:0] REG_OWN_IP    = 2'd1;
    localparam logic [1:0] REG_NET_READY = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        frame_long_enough;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] operation;
        logic [47:0] src_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [31:0] query_ip;
    } arpc_in_t;

    typedef struct packed {
        logic        lookup_hit;
        logic [47:0] lookup_mac;
        logic        send_valid;
        logic [47:0] send_dest_mac;
        logic [1:0]  send_opcode;
        logic [47:0] send_target_mac;
        logic [31:0] send_target_ip;
        logic [4:0]  entry_count;
    } arpc_out_t;

    // table action of one word
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_LEARN  = 2'd1,
        ACT_LOOKUP = 2'd2
    } arpc_act_t;

    // frame to send for one word
    typedef enum logic [1:0] {
        SND_NONE    = 2'd0,
        SND_REPLY   = 2'd1,
        SND_REQUEST = 2'd2
    } arpc_snd_t;

    typedef struct packed {
        arpc_act_t   act;
        arpc_snd_t   snd;
        logic [31:0] key_ip;
        logic [47:0] mac;
    } arpc_item_t;

endpackage

`default_nettype wire

### design/arpc_front.sv
// ============================================================================
// arpc_front: input word classifier and command queue
// Checks frames, decides learn/lookup/send and queues the result for the back.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arpc_front
    import arpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire arpc_in_t    s_data,
    input  wire logic [31:0] own_ip,
    input  wire logic        net_ready,
    output logic             q_valid,
    output arpc_item_t       q_item,
    input  wire logic        q_pop
);

    arpc_item_t  q_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        frame_ok;
    logic        push;
    arpc_item_t  cls;

    always_comb begin
        frame_ok = s_data.frame_long_enough
                && (s_data.hw_type == HW_TYPE_ETH)
                && (s_data.proto_type == PROTO_IPV4)
                && (s_data.hw_len == HW_ADDR_LEN)
                && (s_data.proto_len == PROTO_ADDR_LEN);
        cls.act    = ACT_NONE;
        cls.snd    = SND_NONE;
        cls.key_ip = s_data.query_ip;
        cls.mac    = s_data.src_mac;
        unique case (s_data.cmd)
            CMD_RECEIVE: begin
                cls.key_ip = s_data.src_ip;
                if (frame_ok && (s_data.src_ip != '0)) begin
                    cls.act = ACT_LEARN;
                end
                if (frame_ok && (s_data.operation == ARP_OP_REQUEST) && net_ready
                        && (s_data.dst_ip == own_ip)) begin
                    cls.snd = SND_REPLY;
                end
            end
            CMD_LOOKUP: begin
                cls.act = ACT_LOOKUP;
            end
            CMD_SEND: begin
                if (net_ready && (s_data.query_ip != '0)) begin
                    cls.snd = SND_REQUEST;
                end
            end
            default: begin
                cls.act = ACT_NONE;
            end
        endcase
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

### design/arpc_back.sv
// ============================================================================
// arpc_back: table engine and result register
// Scans the table one entry a cycle, applies learning and builds the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arpc_back
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       q_valid,
    input  wire arpc_item_t q_item,
    output logic            q_pop,
    output logic            m_valid,
    input  wire logic       m_ready,
    output arpc_out_t       m_data
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } back_state_t;

    back_state_t state_reg, state_next;
    arpc_item_t  cur_reg, cur_next;

    // table storage; used bits are flops, ip/mac live in memory
    logic [TABLE_ENTRIES-1:0] used_reg, used_next;
    logic [31:0]              mem_ip  [TABLE_ENTRIES];
    logic [47:0]              mem_mac [TABLE_ENTRIES];
    logic [31:0]              rd_ip_reg;
    logic [47:0]              rd_mac_reg;

    logic [IW-1:0] issue_idx_reg, issue_idx_next;
    logic          issue_on_reg, issue_on_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;
    logic          cmp_on_reg, cmp_on_next;

    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [47:0]   hit_mac_reg, hit_mac_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [IW-1:0] rep_ptr_reg, rep_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    logic          m_valid_reg, m_valid_next;
    arpc_out_t     m_data_reg, m_data_next;

    logic          out_free;
    logic          finish;
    logic          match;
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    arpc_out_t     res;

    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == ST_DONE) && out_free;
    assign match    = cmp_on_reg && used_reg[cmp_idx_reg] && (rd_ip_reg == cur_reg.key_ip);
    assign wr_en    = finish && (cur_reg.act == ACT_LEARN);
    assign wr_idx   = hit_reg ? hit_idx_reg : (free_reg ? free_idx_reg : rep_ptr_reg);
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;

    // result word for the item in flight
    always_comb begin
        res = '0;
        if ((cur_reg.act == ACT_LOOKUP) && hit_reg) begin
            res.lookup_hit = 1'b1;
            res.lookup_mac = hit_mac_reg;
        end
        unique case (cur_reg.snd)
            SND_REPLY: begin
                res.send_valid      = 1'b1;
                res.send_dest_mac   = cur_reg.mac;
                res.send_opcode     = OPC_REPLY;
                res.send_target_mac = cur_reg.mac;
                res.send_target_ip  = cur_reg.key_ip;
            end
            SND_REQUEST: begin
                res.send_valid      = 1'b1;
                res.send_dest_mac   = BCAST_MAC;
                res.send_opcode     = OPC_REQUEST;
                res.send_target_mac = '0;
                res.send_target_ip  = cur_reg.key_ip;
            end
            default: begin
                res.send_valid = 1'b0;
            end
        endcase
        res.entry_count = 5'(count_next);
    end

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        used_next      = used_reg;
        issue_idx_next = issue_idx_reg;
        issue_on_next  = issue_on_reg;
        cmp_idx_next   = issue_idx_reg;
        cmp_on_next    = 1'b0;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        hit_mac_next   = hit_mac_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        rep_ptr_next   = rep_ptr_reg;
        count_next     = count_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cur_next       = q_item;
                    hit_next       = 1'b0;
                    free_next      = 1'b0;
                    issue_idx_next = '0;
                    issue_on_next  = 1'b1;
                    if ((q_item.act == ACT_LEARN) || (q_item.act == ACT_LOOKUP)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // read issue runs one entry ahead of the compare
                cmp_on_next = issue_on_reg;
                if (issue_on_reg) begin
                    if (issue_idx_reg == LAST_IDX) begin
                        issue_on_next = 1'b0;
                    end else begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
                if (match) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_mac_next = rd_mac_reg;
                    cmp_on_next  = 1'b0;
                    state_next   = ST_DONE;
                end else if (cmp_on_reg) begin
                    if (!used_reg[cmp_idx_reg] && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                    if (cmp_idx_reg == LAST_IDX) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (cur_reg.act == ACT_LEARN && !hit_reg) begin
                        if (free_reg) begin
                            used_next[free_idx_reg] = 1'b1;
                            count_next              = CW'(count_reg + 1'b1);
                        end else begin
                            rep_ptr_next = (rep_ptr_reg == LAST_IDX) ? '0
                                                                     : rep_ptr_reg + 1'b1;
                        end
                    end
                    m_valid_next = 1'b1;
                    m_data_next  = res;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            issue_on_reg <= 1'b0;
            cmp_on_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            rep_ptr_reg  <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            issue_on_reg <= issue_on_next;
            cmp_on_reg   <= cmp_on_next;
            hit_reg      <= hit_next;
            free_reg     <= free_next;
            rep_ptr_reg  <= rep_ptr_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_mac_reg   <= hit_mac_next;
        free_idx_reg  <= free_idx_next;
        m_data_reg    <= m_data_next;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_ip[wr_idx]  <= cur_reg.key_ip;
            mem_mac[wr_idx] <= cur_reg.mac;
        end
        rd_ip_reg  <= mem_ip[issue_idx_reg];
        rd_mac_reg <= mem_mac[issue_idx_reg];
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_count_tracks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(used_reg) == int'(count_reg))
        else $error("entry count out of step with used bits");

    a_hit_is_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && hit_reg |-> used_reg[hit_idx_reg])
        else $error("hit on an unused entry");

    a_scan_needs_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cur_reg.act == ACT_LEARN) || (cur_reg.act == ACT_LOOKUP))
        else $error("table scan for a word without table action");

    a_result_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("finished word did not reach the result register");
`endif

endmodule

`default_nettype wire

### design/arp_cache_responder.sv
// ============================================================================
// arp_cache_responder: ARP table with request generator and reply responder
// Configuration registers, front classifier/queue and back table engine.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one command word (receive frame, lookup,
//   send request); m_valid/m_ready/m_data return exactly one result word for
//   each command. The APB port holds own_mac (0x00), own_ip (0x08) and
//   net_ready (0x10); write it only while no word is in flight.
//   A word without a table action (send request, dropped frame, zero sender
//   address) passes through the queue, the engine's word register and the
//   result register. Learn and lookup scan the table one entry a cycle
//   through the single read port of the table memory, and stop early when
//   a lookup or update hits. One word is in the engine at a time, so it
//   takes a new word only once the last one is finished; a two-word queue
//   in front lets s_ready stay high meanwhile.
//   Reset clears the table valid bits, entry count, replacement pointer and
//   the control and valid flags at once; no clearing pass is needed.
//   A stalled m_ready holds the result; the engine finishes its current word
//   and waits, and the queue fills before s_ready drops.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_responder
    import arpc_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire arpc_in_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output arpc_out_t        m_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic [47:0] own_mac_reg;
    logic [31:0] own_ip_reg;
    logic        net_ready_reg;
    logic [1:0]  reg_idx;
    logic        cfg_wr;

    logic        q_valid;
    arpc_item_t  q_item;
    logic        q_pop;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_mac_reg   <= '0;
            own_ip_reg    <= '0;
            net_ready_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_OWN_MAC:   own_mac_reg   <= pwdata[47:0];
                REG_OWN_IP:    own_ip_reg    <= pwdata[31:0];
                REG_NET_READY: net_ready_reg <= pwdata[0];
                default: begin
                    own_mac_reg <= own_mac_reg;
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OWN_MAC:   prdata = {16'd0, own_mac_reg};
            REG_OWN_IP:    prdata = {32'd0, own_ip_reg};
            REG_NET_READY: prdata = {63'd0, net_ready_reg};
            default:       prdata = '0;
        endcase
    end

    arpc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .own_ip    (own_ip_reg),
        .net_ready (net_ready_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    arpc_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### sim/arp_cache_responder_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// arp_cache_responder_tb: self-checking bench for the ARP cache responder
// Drives command words through valid/ready with bursty gaps and a stalling
// receiver. Registers are set over APB between phases. A scoreboard keeps its
// own copy of the ARP table and predicts every result word.
// ============================================================================

module arp_cache_responder_tb;
    import arpc_pkg::*;

    localparam int          TABLE_ENTRIES  = 16;
    localparam int          POOL_SIZE      = 24;
    localparam int          PHASES         = 6;
    localparam int          WORDS_PER_PASS = 105;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          TAIL_CYCLES    = 48;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;

    // ------------------------------------------------------------------------
    // ARP table predictor and result scoreboard
    // ------------------------------------------------------------------------
    class arp_cache_sb;
        logic        slot_used [TABLE_ENTRIES];
        logic [31:0] slot_ip   [TABLE_ENTRIES];
        logic [47:0] slot_mac  [TABLE_ENTRIES];
        int          victim;
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic        net_ready;
        arpc_out_t   pending_answers[$];
        int          mismatches;
        int          n_results;
        int          n_frames, n_dropped, n_lookups, n_hits;
        int          n_requests, n_replies, n_replaced, n_unused;

        function new();
            foreach (slot_used[i]) begin
                slot_used[i] = 1'b0;
                slot_ip[i]   = '0;
                slot_mac[i]  = '0;
            end
            victim     = 0;
            own_mac    = '0;
            own_ip     = '0;
            net_ready  = 1'b0;
            mismatches = 0;
            n_results  = 0;
            n_frames   = 0;
            n_dropped  = 0;
            n_lookups  = 0;
            n_hits     = 0;
            n_requests = 0;
            n_replies  = 0;
            n_replaced = 0;
            n_unused   = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_OWN_MAC:   own_mac = val[47:0];
                REG_OWN_IP:    own_ip = val[31:0];
                REG_NET_READY: net_ready = val[0];
                default: ;
            endcase
        endfunction

        // update a matching entry, else first free slot, else round-robin victim
        function void learn_pair(logic [31:0] ip, logic [47:0] mac);
            if (ip == '0)
                return;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (slot_used[i] && slot_ip[i] == ip) begin
                    slot_mac[i] = mac;
                    return;
                end
            end
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!slot_used[i]) begin
                    slot_used[i] = 1'b1;
                    slot_ip[i]   = ip;
                    slot_mac[i]  = mac;
                    return;
                end
            end
            slot_used[victim] = 1'b1;
            slot_ip[victim]   = ip;
            slot_mac[victim]  = mac;
            victim = (victim + 1) % TABLE_ENTRIES;
            n_replaced++;
        endfunction

        function void note_word(arpc_in_t w);
            arpc_out_t  e;
            logic       found;
            logic [4:0] used;
            e = '0;
            found = 1'b0;
            used = '0;
            case (w.cmd)
                CMD_RECEIVE: begin
                    n_frames++;
                    if (w.frame_long_enough && w.hw_type == HW_TYPE_ETH &&
                        w.proto_type == PROTO_IPV4 &&
                        w.hw_len == HW_ADDR_LEN &&
                        w.proto_len == PROTO_ADDR_LEN) begin
                        learn_pair(w.src_ip, w.src_mac);
                        if (w.operation == ARP_OP_REQUEST && net_ready &&
                            w.dst_ip == own_ip) begin
                            e.send_valid      = 1'b1;
                            e.send_dest_mac   = w.src_mac;
                            e.send_opcode     = OPC_REPLY;
                            e.send_target_mac = w.src_mac;
                            e.send_target_ip  = w.src_ip;
                            n_replies++;
                        end
                    end else begin
                        n_dropped++;
                    end
                end
                CMD_LOOKUP: begin
                    n_lookups++;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!found && slot_used[i] && slot_ip[i] == w.query_ip) begin
                            found        = 1'b1;
                            e.lookup_hit = 1'b1;
                            e.lookup_mac = slot_mac[i];
                        end
                    end
                    if (found)
                        n_hits++;
                end
                CMD_SEND: begin
                    if (net_ready && w.query_ip != '0) begin
                        e.send_valid      = 1'b1;
                        e.send_dest_mac   = BCAST_MAC;
                        e.send_opcode     = OPC_REQUEST;
                        e.send_target_mac = '0;
                        e.send_target_ip  = w.query_ip;
                        n_requests++;
                    end
                end
                default: n_unused++;
            endcase
            foreach (slot_used[i])
                if (slot_used[i])
                    used++;
            e.entry_count = used;
            pending_answers.push_back(e);
        endfunction

        function int outstanding();
            return pending_answers.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endtask

        task check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                          n_results, name, got, want));
        endtask

        task check_result(arpc_out_t got);
            arpc_out_t e;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no word outstanding",
                                          n_results));
            end else begin
                e = pending_answers.pop_front();
                check_field("lookup_hit", 64'(got.lookup_hit), 64'(e.lookup_hit));
                check_field("lookup_mac", 64'(got.lookup_mac), 64'(e.lookup_mac));
                check_field("send_valid", 64'(got.send_valid), 64'(e.send_valid));
                check_field("send_dest_mac", 64'(got.send_dest_mac),
                            64'(e.send_dest_mac));
                check_field("send_opcode", 64'(got.send_opcode), 64'(e.send_opcode));
                check_field("send_target_mac", 64'(got.send_target_mac),
                            64'(e.send_target_mac));
                check_field("send_target_ip", 64'(got.send_target_ip),
                            64'(e.send_target_ip));
                check_field("entry_count", 64'(got.entry_count), 64'(e.entry_count));
            end
            n_results++;
        endtask

        task close_out();
            while (pending_answers.size() != 0) begin
                void'(pending_answers.pop_front());
                report_mismatch("expected result never arrived");
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    arpc_in_t    s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    arpc_out_t   m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [63:0] pwdata  = '0;
    logic [63:0] prdata;
    logic        pready;

    arp_cache_sb sb;
    logic [31:0] ip_pool [POOL_SIZE];
    int          burst_left  = 0;
    logic        idle_sender = 1'b1;
    int          quiet_cycles = 0;
    logic [31:0] stall_pat = '0;
    int          stall_left = 0;

    always #1 aclk = ~aclk;

    arp_cache_responder #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // receiver stalls on a rotating pattern; some windows are always ready
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_pat  = ($urandom_range(0, 3) == 0) ? '1 : ($urandom | $urandom);
            stall_left = 64;
        end
        m_ready <= stall_pat[0];
        stall_pat  = {stall_pat[0], stall_pat[31:1]};
        stall_left = stall_left - 1;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_word(input arpc_in_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = idle_sender ? $urandom_range(1, 10) : 0;
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
    endtask

    // hold the sender until every outstanding word has its result
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Word builders
    // ------------------------------------------------------------------------
    function automatic arpc_in_t noise_word();
        logic [255:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(arpc_in_t)-1:0];
    endfunction

    function automatic arpc_in_t frame_word(logic [15:0] op, logic [47:0] mac,
                                            logic [31:0] sip, logic [31:0] tip);
        arpc_in_t w;
        w = noise_word();
        w.cmd               = CMD_RECEIVE;
        w.frame_long_enough = 1'b1;
        w.hw_type           = HW_TYPE_ETH;
        w.proto_type        = PROTO_IPV4;
        w.hw_len            = HW_ADDR_LEN;
        w.proto_len         = PROTO_ADDR_LEN;
        w.operation         = op;
        w.src_mac           = mac;
        w.src_ip            = sip;
        w.dst_ip            = tip;
        return w;
    endfunction

    function automatic arpc_in_t query_word(logic [1:0] c, logic [31:0] q);
        arpc_in_t w;
        w = noise_word();
        w.cmd      = c;
        w.query_ip = q;
        return w;
    endfunction

    function automatic logic [31:0] pool_ip();
        return ip_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // over half frames, mostly well-formed, over a small address pool, so the table fills,
    // updates and wraps; the rest is broken headers, lookups, requests, noise
    function automatic arpc_in_t random_word();
        arpc_in_t    w;
        int          r;
        logic [63:0] rnd;
        logic [63:0] junk;
        logic [15:0] op;
        logic [31:0] sip;
        logic [31:0] tip;
        r    = $urandom_range(0, 99);
        rnd  = {$urandom, $urandom};
        junk = {$urandom, $urandom};
        if (r < 55) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: op = ARP_OP_REQUEST;
                12, 13, 14, 15, 16:                   op = ARP_OP_REPLY;
                default:                              op = junk[15:0];
            endcase
            case ($urandom_range(0, 19))
                0:       sip = '0;
                1, 2:    sip = junk[63:32];
                default: sip = pool_ip();
            endcase
            tip = ($urandom_range(0, 1) == 0) ? sb.own_ip :
                  ($urandom_range(0, 1) == 0) ? pool_ip() : junk[47:16];
            w = frame_word(op, rnd[47:0], sip, tip);
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 5))
                    0: w.frame_long_enough = 1'b0;
                    1: w.hw_type = junk[15:0];
                    2: w.proto_type = ($urandom_range(0, 1) == 0) ? ETH_TYPE_ARP
                                                                  : junk[31:16];
                    3: w.hw_len = junk[7:0];
                    4: w.proto_len = junk[15:8];
                    default: begin
                        w = noise_word();
                        w.cmd = CMD_RECEIVE;
                    end
                endcase
            end
        end else if (r < 75) begin
            case ($urandom_range(0, 9))
                0:       w = query_word(CMD_LOOKUP, '0);
                1, 2:    w = query_word(CMD_LOOKUP, junk[31:0]);
                default: w = query_word(CMD_LOOKUP, pool_ip());
            endcase
        end else if (r < 93) begin
            w = query_word(CMD_SEND, ($urandom_range(0, 9) == 0) ? '0 : junk[31:0]);
        end else begin
            w = query_word(CMD_UNUSED, junk[31:0]);
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        arpc_in_t    w;
        logic [63:0] rnd;
        logic [47:0] mac_set   [PHASES];
        logic [31:0] ip_set    [PHASES];
        logic        ready_set [PHASES];

        sb = new();
        foreach (ip_pool[i])
            ip_pool[i] = $urandom | 32'h1;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'h0000_0001;

        rnd = {$urandom, $urandom};
        mac_set = '{48'h0, 48'hFFFF_FFFF_FFFF, rnd[47:0], rnd[63:16],
                    {rnd[31:0], rnd[63:48]}, 48'h0123_4567_89AB};
        ip_set    = '{ip_pool[0], 32'hFFFF_FFFF, 32'h0, ip_pool[5], ip_pool[9], $urandom};
        ready_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++) begin
            write_reg(REG_OWN_MAC, {16'h0, mac_set[ph]});
            write_reg(REG_OWN_IP, {32'h0, ip_set[ph]});
            write_reg(REG_NET_READY, {63'h0, ready_set[ph]});
            idle_sender = (ph != 2);

            if (ph == 0) begin
                push_word(query_word(CMD_LOOKUP, '0));
                push_word(query_word(CMD_SEND, '0));
                push_word(query_word(CMD_SEND, 32'hFFFF_FFFF));
                push_word(query_word(CMD_SEND, 32'h1));
                // request for us from an all-ones MAC: learn and reply
                push_word(frame_word(ARP_OP_REQUEST, 48'hFFFF_FFFF_FFFF, ip_pool[1],
                                     sb.own_ip));
                // zero sender address: replied to but not learned
                push_word(frame_word(ARP_OP_REQUEST, 48'h0, 32'h0, sb.own_ip));
                push_word(frame_word(ARP_OP_REPLY, rnd[47:0], ip_pool[2], sb.own_ip));
                push_word(frame_word(16'hFFFF, rnd[63:16], ip_pool[6], sb.own_ip));
                push_word(frame_word(ARP_OP_REQUEST, rnd[55:8], ip_pool[3], ip_pool[7]));
                // same address again with a new MAC updates in place
                push_word(frame_word(ARP_OP_REPLY, 48'h0123_4567_89AB, ip_pool[1],
                                     ip_pool[7]));
                // each header check fails on its own
                w = frame_word(ARP_OP_REQUEST, rnd[47:0], ip_pool[4], sb.own_ip);
                w.frame_long_enough = 1'b0;
                push_word(w);
                w = frame_word(ARP_OP_REQUEST, rnd[47:0], ip_pool[4], sb.own_ip);
                w.hw_type = 16'hFFFF;
                push_word(w);
                w = frame_word(ARP_OP_REQUEST, rnd[47:0], ip_pool[4], sb.own_ip);
                w.proto_type = ETH_TYPE_ARP;
                push_word(w);
                w = frame_word(ARP_OP_REQUEST, rnd[47:0], ip_pool[4], sb.own_ip);
                w.hw_len = 8'hFF;
                push_word(w);
                w = frame_word(ARP_OP_REQUEST, rnd[47:0], ip_pool[4], sb.own_ip);
                w.proto_len = 8'h00;
                push_word(w);
                push_word(query_word(CMD_LOOKUP, ip_pool[4]));
                push_word(query_word(CMD_LOOKUP, ip_pool[1]));
                push_word(query_word(CMD_LOOKUP, ip_pool[2]));
                push_word(query_word(CMD_LOOKUP, '0));
                push_word(query_word(CMD_UNUSED, ip_pool[1]));
                push_word(query_word(CMD_LOOKUP, ip_pool[1]));
                drain_results();
            end

            for (int k = 0; k < WORDS_PER_PASS; k++) begin
                push_word(random_word());
                if (k == WORDS_PER_PASS / 2)
                    drain_results();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        sb.close_out();

        $display("Ran %0d results: %0d frames (%0d dropped), %0d lookups (%0d hits)",
                 sb.n_results, sb.n_frames, sb.n_dropped, sb.n_lookups, sb.n_hits);
        $display("%0d replies, %0d requests, %0d table replacements, %0d unused cmds, %0d %s",
                 sb.n_replies, sb.n_requests, sb.n_replaced, sb.n_unused, sb.mismatches,
                 "mismatches");
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
